>>> sv/gb5_pkg.sv
// Shared types, register indexes and constants of the 5x5 RGB Gaussian blur.
// No dependencies.
package gb5_pkg;

  localparam int PIX_W   = 24;
  localparam int COEF_W  = 16;
  localparam int NCOEF   = 6;
  localparam int CLS_W   = 3;
  localparam int CLS_NONE = 6;
  localparam int ROW_W   = 12;
  localparam int HGT_W   = 13;
  localparam int WID_W   = 11;
  localparam int MAX_HEIGHT = 4096;
  localparam int NBANK   = 4;
  localparam int BANK_W  = 2;
  localparam int SLOT_W  = 3;
  localparam int MAX_K   = 5;
  localparam int GSUM_W  = 11;
  localparam int PROD_W  = 27;
  localparam int ACC_W   = 30;
  localparam int OUT_DEPTH = 8;
  localparam int OPTR_W  = 3;
  localparam int OCNT_W  = 4;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_COEF0  = 3'd2;
  localparam logic [2:0] CFG_COEF1  = 3'd3;
  localparam logic [2:0] CFG_COEF2  = 3'd4;
  localparam logic [2:0] CFG_COEF4  = 3'd5;
  localparam logic [2:0] CFG_COEF5  = 3'd6;
  localparam logic [2:0] CFG_COEF8  = 3'd7;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [NCOEF-1:0][COEF_W-1:0] coef_t;

  // window description handed from the sequencer to the filter datapath
  typedef struct packed {
    logic                             last;
    logic                             row_start;
    logic [MAX_K-1:0][BANK_W-1:0]     bsel;
    logic [MAX_K-1:0][SLOT_W-1:0]     rslot;
  } emit_t;

  // weight class by squared distance from the center
  function automatic logic [CLS_W-1:0] coef_class(input int di, input int dj);
    int dd;
    dd = di * di + dj * dj;
    case (dd)
      0: return CLS_W'(0);
      1: return CLS_W'(1);
      2: return CLS_W'(2);
      4: return CLS_W'(3);
      5: return CLS_W'(4);
      8: return CLS_W'(5);
      default: return CLS_W'(CLS_NONE);
    endcase
  endfunction

endpackage

>>> sv/gb5_line_mem.sv
// One bank of one buffered image row: synchronous RAM, registered read.
// Same-address write and read in a cycle returns the new data. Uses no package.
module gb5_line_mem #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= (we && waddr == raddr) ? wdata : mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/gb5_ctrl.sv
// Frame sequencer: input/output raster counters, readiness, line store
// write and read addressing. Depends on gb5_pkg.
module gb5_ctrl #(
  parameter int MAX_WIDTH   = 1024,
  parameter int KERNEL_SIZE = 5,
  parameter int RING        = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           acc,
  input  logic                           drain,
  input  logic                           restart,
  input  logic [gb5_pkg::WID_W-1:0]      width,
  input  logic [gb5_pkg::HGT_W-1:0]      height,
  output logic                           wr_en,
  output logic [gb5_pkg::SLOT_W-1:0]     wr_slot,
  output logic [$clog2(MAX_WIDTH)-1:0]   wr_col,
  output logic                           rd_en,
  output logic [$clog2(MAX_WIDTH)-gb5_pkg::BANK_W-1:0] rd_addr,
  output logic                           emit,
  output logic                           s1_v,
  output gb5_pkg::emit_t                 s1
);

  localparam int R  = KERNEL_SIZE / 2;
  localparam int K  = 2 * R + 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CW + 1 > gb5_pkg::WID_W) ? CW + 1 : gb5_pkg::WID_W;
  localparam int RW = gb5_pkg::ROW_W;
  localparam int SW = gb5_pkg::SLOT_W;

  logic [CW-1:0] ic_r, ic_nxt, oc_r, oc_nxt;
  logic [RW-1:0] ir_r, ir_nxt, or_r, or_nxt;
  logic [SW-1:0] islot_r, islot_nxt, oslot_r, oslot_nxt;
  logic          in_done_r, in_done_nxt, out_done_r, out_done_nxt;
  logic          s1_v_r;
  gb5_pkg::emit_t s1_r, s1_nxt;

  logic [CW-1:0] wm1;
  logic [RW-1:0] hm1;
  logic          pix, rst_frame;
  logic [CW-1:0] ic0, oc0;
  logic [RW-1:0] ir0, or0;
  logic [SW-1:0] islot0, oslot0;
  logic          out_done0;
  logic [RW:0]   nr_w;
  logic [RW-1:0] nr;
  logic [CW:0]   nc_w;
  logic [CW-1:0] nc;
  logic          ready;
  logic signed [RW+1:0] rr, de;
  logic signed [4:0]    sa;

  always_comb begin
    if (width == '0) begin
      wm1 = '0;
    end else if (EW'(width) > EW'(MAX_WIDTH)) begin
      wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      wm1 = CW'(width - gb5_pkg::WID_W'(1));
    end
    if (height == '0) begin
      hm1 = '0;
    end else if (height > gb5_pkg::HGT_W'(gb5_pkg::MAX_HEIGHT)) begin
      hm1 = RW'(gb5_pkg::MAX_HEIGHT - 1);
    end else begin
      hm1 = RW'(height - gb5_pkg::HGT_W'(1));
    end
  end

  always_comb begin
    pix       = !drain;
    rst_frame = pix && in_done_r;
    ic0       = rst_frame ? '0 : ic_r;
    ir0       = rst_frame ? '0 : ir_r;
    islot0    = rst_frame ? '0 : islot_r;
    oc0       = rst_frame ? '0 : oc_r;
    or0       = rst_frame ? '0 : or_r;
    oslot0    = rst_frame ? '0 : oslot_r;
    out_done0 = rst_frame ? 1'b0 : out_done_r;

    ic_nxt      = ic0;
    ir_nxt      = ir0;
    islot_nxt   = islot0;
    in_done_nxt = rst_frame ? 1'b0 : in_done_r;
    if (pix) begin
      if (ic0 == wm1) begin
        ic_nxt = '0;
        if (ir0 == hm1) begin
          ir_nxt      = '0;
          islot_nxt   = '0;
          in_done_nxt = 1'b1;
        end else begin
          ir_nxt    = ir0 + RW'(1);
          islot_nxt = (islot0 == SW'(RING - 1)) ? '0 : islot0 + SW'(1);
        end
      end else begin
        ic_nxt = ic0 + CW'(1);
      end
    end

    nr_w = {1'b0, or0} + (RW + 1)'(R);
    nr   = (nr_w > {1'b0, hm1}) ? hm1 : nr_w[RW-1:0];
    nc_w = {1'b0, oc0} + (CW + 1)'(R);
    nc   = (nc_w > {1'b0, wm1}) ? wm1 : nc_w[CW-1:0];
    ready = !out_done0 &&
            (in_done_nxt || ir_nxt > nr || (ir_nxt == nr && ic_nxt > nc));
    emit = acc && ready;

    oc_nxt       = oc0;
    or_nxt       = or0;
    oslot_nxt    = oslot0;
    out_done_nxt = out_done0;
    if (ready) begin
      if (oc0 == wm1) begin
        oc_nxt = '0;
        if (or0 == hm1) begin
          or_nxt       = '0;
          oslot_nxt    = '0;
          out_done_nxt = 1'b1;
        end else begin
          or_nxt    = or0 + RW'(1);
          oslot_nxt = (oslot0 == SW'(RING - 1)) ? '0 : oslot0 + SW'(1);
        end
      end else begin
        oc_nxt = oc0 + CW'(1);
      end
    end

    s1_nxt           = '0;
    s1_nxt.last      = (oc0 == wm1) && (or0 == hm1);
    s1_nxt.row_start = (oc0 == '0);
    rr = '0;
    de = '0;
    sa = '0;
    for (int j = 0; j < K; j++) begin
      if (oc0 != '0) begin
        s1_nxt.bsel[j] = nc[gb5_pkg::BANK_W-1:0];
      end else if (wm1 < CW'((j >= R) ? j - R : 0)) begin
        s1_nxt.bsel[j] = wm1[gb5_pkg::BANK_W-1:0];
      end else begin
        s1_nxt.bsel[j] = gb5_pkg::BANK_W'((j >= R) ? j - R : 0);
      end
    end
    for (int i = 0; i < K; i++) begin
      rr = $signed({2'b00, or0}) + $signed((RW + 2)'(i - R));
      if (rr < 0) begin
        rr = '0;
      end else if (rr > $signed({2'b00, hm1})) begin
        rr = $signed({2'b00, hm1});
      end
      de = rr - $signed({2'b00, or0});
      sa = $signed({2'b00, oslot0}) + $signed(de[4:0]);
      if (sa < 0) begin
        sa = sa + 5'(RING);
      end else if (sa >= $signed(5'(RING))) begin
        sa = sa - 5'(RING);
      end
      s1_nxt.rslot[i] = sa[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      ic_r       <= '0;
      ir_r       <= '0;
      oc_r       <= '0;
      or_r       <= '0;
      islot_r    <= '0;
      oslot_r    <= '0;
      in_done_r  <= 1'b0;
      out_done_r <= 1'b0;
    end else if (acc) begin
      ic_r       <= ic_nxt;
      ir_r       <= ir_nxt;
      oc_r       <= oc_nxt;
      or_r       <= or_nxt;
      islot_r    <= islot_nxt;
      oslot_r    <= oslot_nxt;
      in_done_r  <= in_done_nxt;
      out_done_r <= out_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      s1_r <= s1_nxt;
    end
  end

  assign wr_en   = acc && pix;
  assign wr_slot = islot0;
  assign wr_col  = ic0;
  assign rd_en   = emit;
  assign rd_addr = (oc0 == '0) ? '0 : nc[CW-1:gb5_pkg::BANK_W];
  assign s1_v    = s1_v_r;
  assign s1      = s1_r;

endmodule

>>> sv/gb5_filter.sv
// Filter datapath: window registers, per-class pixel sums, coefficient
// products, rounding and saturation. Depends on gb5_pkg.
module gb5_filter #(
  parameter int KERNEL_SIZE = 5,
  parameter int RING        = 6
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  logic                                             s1_v,
  input  gb5_pkg::emit_t                                   s1,
  input  logic [RING-1:0][gb5_pkg::NBANK-1:0][gb5_pkg::PIX_W-1:0] rd_data,
  input  gb5_pkg::coef_t                                   coef,
  output logic                                             res_v,
  output logic [gb5_pkg::PIX_W:0]                          res
);

  localparam int R  = KERNEL_SIZE / 2;
  localparam int K  = 2 * R + 1;
  localparam int SW = $clog2(RING);
  localparam int NC = gb5_pkg::NCOEF;

  gb5_pkg::pix_t [K-1:0][K-1:0] win_r, win_nxt;
  logic [NC-1:0][2:0][gb5_pkg::GSUM_W-1:0] gs_nxt, gs_r;
  logic [NC-1:0][2:0][gb5_pkg::PROD_W-1:0] prod_r;
  logic [2:0][gb5_pkg::ACC_W-1:0]          acc;
  logic [2:0][gb5_pkg::ACC_W-17:0]         rnd;
  logic [gb5_pkg::PIX_W-1:0]               chan;
  logic s2_v_r, s3_v_r, s4_v_r, res_v_r;
  logic s2_last_r, s3_last_r, s4_last_r;
  logic [gb5_pkg::PIX_W:0] res_r;
  logic [gb5_pkg::CLS_W-1:0] cls;

  always_comb begin
    win_nxt = win_r;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K - 1; j++) begin
        win_nxt[i][j] = s1.row_start ?
                        rd_data[s1.rslot[i][SW-1:0]][s1.bsel[j]] : win_r[i][j+1];
      end
      win_nxt[i][K-1] = rd_data[s1.rslot[i][SW-1:0]][s1.bsel[K-1]];
    end
  end

  always_comb begin
    gs_nxt = '0;
    cls    = '0;
    for (int i = 0; i < K; i++) begin
      for (int j = 0; j < K; j++) begin
        cls = gb5_pkg::coef_class(i - R, j - R);
        if (cls < gb5_pkg::CLS_W'(gb5_pkg::CLS_NONE)) begin
          for (int ch = 0; ch < 3; ch++) begin
            gs_nxt[cls][ch] = gs_nxt[cls][ch] +
                              gb5_pkg::GSUM_W'(win_r[i][j][8*ch +: 8]);
          end
        end
      end
    end
  end

  always_comb begin
    chan = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc[ch] = gb5_pkg::ACC_W'(32768);
      for (int c = 0; c < NC; c++) begin
        acc[ch] = acc[ch] + gb5_pkg::ACC_W'(prod_r[c][ch]);
      end
      rnd[ch] = acc[ch][gb5_pkg::ACC_W-1:16];
      chan[8*ch +: 8] = (|rnd[ch][gb5_pkg::ACC_W-17:8]) ? 8'hFF : rnd[ch][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v) begin
      win_r     <= win_nxt;
      s2_last_r <= s1.last;
    end
    if (s2_v_r) begin
      gs_r      <= gs_nxt;
      s3_last_r <= s2_last_r;
    end
    if (s3_v_r) begin
      for (int c = 0; c < NC; c++) begin
        for (int ch = 0; ch < 3; ch++) begin
          prod_r[c][ch] <= gb5_pkg::PROD_W'(gs_r[c][ch]) * gb5_pkg::PROD_W'(coef[c]);
        end
      end
      s4_last_r <= s3_last_r;
    end
    if (s4_v_r) begin
      res_r <= {s4_last_r, chan};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      res_v_r <= 1'b0;
    end else begin
      s2_v_r  <= s1_v;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      res_v_r <= s4_v_r;
    end
  end

  assign res_v = res_v_r;
  assign res   = res_r;

endmodule

>>> sv/gb5_out_fifo.sv
// Result queue between the filter pipeline and the output channel.
// Depends on gb5_pkg.
module gb5_out_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  logic [gb5_pkg::PIX_W:0] wr_data,
  input  logic                    rd_en,
  output logic                    rd_valid,
  output logic [gb5_pkg::PIX_W:0] rd_data
);

  logic [gb5_pkg::PIX_W:0] q_r [gb5_pkg::OUT_DEPTH];
  logic [gb5_pkg::OPTR_W-1:0] wp_r, rp_r;
  logic [gb5_pkg::OCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + gb5_pkg::OPTR_W'(1);
      end
      if (rd_en) begin
        rp_r <= rp_r + gb5_pkg::OPTR_W'(1);
      end
      cnt_r <= cnt_r + gb5_pkg::OCNT_W'(wr_en) - gb5_pkg::OCNT_W'(rd_en);
    end
  end

  assign rd_valid = (cnt_r != '0);
  assign rd_data  = q_r[rp_r];

endmodule

>>> sv/gaussian_blur_5x5_rgb_core.sv
// Top level of the 5x5 RGB Gaussian blur with replicated borders.
// Depends on gb5_pkg, gb5_ctrl, gb5_line_mem, gb5_filter, gb5_out_fifo.
//
// Pixels enter in raster order on in_*: tdata holds blue, green, red and
// tuser is 1 for a drain word, which only pushes out results still due at
// the end of a frame. Blurred pixels leave on out_*, tlast marking the last
// pixel of a frame. Registers are written on cfg_* (always ready); a write
// of width or height restarts the frame. Write them only while idle.
// A word is taken every cycle while in_tready is high. A result passes the
// sequencer, window, sum, product, result and queue registers; one result
// per cycle is sustained while out_tready is high. Each word does one line
// store write and one column read of all buffered rows at once (one RAM per
// row and per column modulo 4, so a row start fetches its three distinct
// border columns together). in_tready falls while 8 results are in flight
// or queued, so a stalled receiver stops the input and nothing is lost.
// After reset: width and height 256, center weight 65535, others 0, frame
// counters cleared. Line store contents need no clearing.
module gaussian_blur_5x5_rgb_core #(
  parameter int MAX_WIDTH   = 1024,
  parameter int KERNEL_SIZE = 5,
  parameter int STORED_ROWS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // in_blue, in_green, in_red
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // out_blue, out_green, out_red
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int R    = KERNEL_SIZE / 2;
  localparam int RING = (STORED_ROWS + 2 > 2 * R + 2) ? STORED_ROWS + 2 : 2 * R + 2;
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int AW   = CW - gb5_pkg::BANK_W;
  localparam int SW   = $clog2(RING);
  localparam int NB   = gb5_pkg::NBANK;

  logic [gb5_pkg::WID_W-1:0] width_r;
  logic [gb5_pkg::HGT_W-1:0] height_r;
  gb5_pkg::coef_t            coef_r;
  logic                      cfg_wr, restart;

  logic                      acc, emit, wr_en, rd_en, s1_v, res_v, out_hs, oq_valid;
  logic [gb5_pkg::SLOT_W-1:0] wr_slot;
  logic [CW-1:0]             wr_col;
  logic [AW-1:0]             rd_addr;
  gb5_pkg::emit_t            s1;
  logic [RING-1:0][NB-1:0][gb5_pkg::PIX_W-1:0] rd_data;
  logic [gb5_pkg::PIX_W:0]   res, oq_data;
  logic [gb5_pkg::OCNT_W-1:0] cred_r;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid;
  assign restart   = cfg_wr && (cfg_index == gb5_pkg::CFG_WIDTH ||
                                cfg_index == gb5_pkg::CFG_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= gb5_pkg::WID_W'(256);
      height_r <= gb5_pkg::HGT_W'(256);
      coef_r   <= '0;
      coef_r[0] <= 16'hFFFF;
    end else if (cfg_wr) begin
      case (cfg_index)
        gb5_pkg::CFG_WIDTH:  width_r   <= cfg_data[gb5_pkg::WID_W-1:0];
        gb5_pkg::CFG_HEIGHT: height_r  <= cfg_data[gb5_pkg::HGT_W-1:0];
        gb5_pkg::CFG_COEF0:  coef_r[0] <= cfg_data;
        gb5_pkg::CFG_COEF1:  coef_r[1] <= cfg_data;
        gb5_pkg::CFG_COEF2:  coef_r[2] <= cfg_data;
        gb5_pkg::CFG_COEF4:  coef_r[3] <= cfg_data;
        gb5_pkg::CFG_COEF5:  coef_r[4] <= cfg_data;
        gb5_pkg::CFG_COEF8:  coef_r[5] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_tready = (cred_r < gb5_pkg::OCNT_W'(gb5_pkg::OUT_DEPTH));
  assign acc       = in_tvalid && in_tready;
  assign out_hs    = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cred_r <= '0;
    end else begin
      cred_r <= cred_r + gb5_pkg::OCNT_W'(emit) - gb5_pkg::OCNT_W'(out_hs);
    end
  end

  gb5_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .KERNEL_SIZE (KERNEL_SIZE),
    .RING        (RING)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .drain   (in_tuser),
    .restart (restart),
    .width   (width_r),
    .height  (height_r),
    .wr_en   (wr_en),
    .wr_slot (wr_slot),
    .wr_col  (wr_col),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .emit    (emit),
    .s1_v    (s1_v),
    .s1      (s1)
  );

  for (genvar s = 0; s < RING; s++) begin : g_row
    for (genvar b = 0; b < NB; b++) begin : g_bank
      gb5_line_mem #(
        .DEPTH (2 ** AW),
        .AW    (AW),
        .DW    (gb5_pkg::PIX_W)
      ) u_mem (
        .clk   (clk),
        .we    (wr_en && wr_slot[SW-1:0] == SW'(s) &&
                wr_col[gb5_pkg::BANK_W-1:0] == gb5_pkg::BANK_W'(b)),
        .waddr (wr_col[CW-1:gb5_pkg::BANK_W]),
        .wdata (in_tdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data[s][b])
      );
    end
  end

  gb5_filter #(
    .KERNEL_SIZE (KERNEL_SIZE),
    .RING        (RING)
  ) u_filter (
    .clk     (clk),
    .rst_n   (rst_n),
    .s1_v    (s1_v),
    .s1      (s1),
    .rd_data (rd_data),
    .coef    (coef_r),
    .res_v   (res_v),
    .res     (res)
  );

  gb5_out_fifo u_oq (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (res_v),
    .wr_data  (res),
    .rd_en    (out_hs),
    .rd_valid (oq_valid),
    .rd_data  (oq_data)
  );

  assign out_tvalid = oq_valid;
  assign out_tdata  = oq_data[gb5_pkg::PIX_W-1:0];
  assign out_tlast  = oq_data[gb5_pkg::PIX_W];

endmodule
